/* rtl/mps_pkg.sv */
// Shared types and constants of the Modbus PDU server.
`timescale 1ns / 1ps
package mps_pkg;

  localparam logic [1:0] MODE_REQ  = 2'd0;
  localparam logic [1:0] MODE_DISC = 2'd1;
  localparam logic [1:0] MODE_IREG = 2'd2;

  localparam logic [2:0] CLS_RBIT  = 3'd0;
  localparam logic [2:0] CLS_RREG  = 3'd1;
  localparam logic [2:0] CLS_W5    = 3'd2;
  localparam logic [2:0] CLS_W6    = 3'd3;
  localparam logic [2:0] CLS_W15   = 3'd4;
  localparam logic [2:0] CLS_W16   = 3'd5;
  localparam logic [2:0] CLS_OTHER = 3'd6;

  localparam logic [3:0] BS_EXC_FC   = 4'd0;
  localparam logic [3:0] BS_EXC_CODE = 4'd1;
  localparam logic [3:0] BS_NB       = 4'd2;
  localparam logic [3:0] BS_BITS     = 4'd3;
  localparam logic [3:0] BS_QTY2     = 4'd4;
  localparam logic [3:0] BS_REG_HI   = 4'd5;
  localparam logic [3:0] BS_REG_LO   = 4'd6;
  localparam logic [3:0] BS_BUF      = 4'd7;
  localparam logic [3:0] BS_HDR      = 4'd8;

  localparam logic [1:0] AS_ECHO = 2'd0;
  localparam logic [1:0] AS_COIL = 2'd1;
  localparam logic [1:0] AS_HI   = 2'd2;
  localparam logic [1:0] AS_LO   = 2'd3;

  localparam logic [1:0] EXC_NONE = 2'd0;
  localparam logic [1:0] EXC_FUNC = 2'd1;
  localparam logic [1:0] EXC_ADDR = 2'd2;
  localparam logic [1:0] EXC_QTY  = 2'd3;

  localparam logic [7:0]  FC_RD_COILS  = 8'd1;
  localparam logic [7:0]  FC_RD_DISC   = 8'd2;
  localparam logic [7:0]  FC_RD_HOLD   = 8'd3;
  localparam logic [7:0]  FC_RD_IREG   = 8'd4;
  localparam logic [7:0]  FC_WR_COIL   = 8'd5;
  localparam logic [7:0]  FC_WR_REG    = 8'd6;
  localparam logic [7:0]  FC_WR_COILS  = 8'd15;
  localparam logic [7:0]  FC_WR_REGS   = 8'd16;

  localparam logic [7:0]  EXC_FLAG  = 8'h80;
  localparam logic [15:0] COIL_ON   = 16'hFF00;
  localparam logic [16:0] MAX_RBIT  = 17'd2000;
  localparam logic [16:0] MAX_RREG  = 17'd125;
  localparam logic [16:0] MAX_W15   = 17'd1968;
  localparam logic [16:0] MAX_W16   = 17'd123;

  typedef struct packed {
    logic       accept;
    logic       clr_step;
    logic       len_clr;
    logic       idx_clr;
    logic       idx_inc;
    logic       acc_load;
    logic       hi_load;
    logic       push;
    logic       push_last;
    logic [3:0] bsel;
    logic [1:0] asel;
    logic       emit_trunc;
    logic       wr_coil_one;
    logic       wr_hold_one;
    logic       wr_coil_bit;
    logic       wr_hold_reg;
  } mps_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       trunc;
    logic       exc;
    logic [2:0] cls;
    logic       last_elem;
    logic       byte_end;
    logic       echo_last;
    logic       hdr_last;
  } mps_sts_t;

endpackage

/* rtl/modbus_pdu_server_top.sv */
// Top level of the Modbus PDU server.
// Request bytes and local writes are accepted on start while idle; busy stays low between them.
// A final request byte starts service: bits or registers are read, single writes echo the
// request, and multiple writes of coils or registers return the request header.
// Response beats leave on out_strobe, one cycle each; the receiver cannot stall.
// After reset a clearing pass zeroes the coil, discrete, holding and input register areas and holds busy.
`timescale 1ns / 1ps
module modbus_pdu_server_top #(
  parameter int COIL_COUNT      = 2048,
  parameter int DISCRETE_COUNT  = 2048,
  parameter int HOLDING_COUNT   = 256,
  parameter int INPUT_REG_COUNT = 256,
  parameter int BUFFER_DEPTH    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  input  logic [15:0] in_local_address,
  input  logic [15:0] in_local_value,
  output logic        out_strobe,
  output logic [31:0] out_response_word,
  output logic [2:0]  out_byte_count,
  output logic        out_final_res,
  output logic        out_status
);

  mps_pkg::mps_cmd_t cmd;
  mps_pkg::mps_sts_t sts;

  mps_ctl u_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .in_last (in_last),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  mps_dp #(
    .COIL_COUNT      (COIL_COUNT),
    .DISCRETE_COUNT  (DISCRETE_COUNT),
    .HOLDING_COUNT   (HOLDING_COUNT),
    .INPUT_REG_COUNT (INPUT_REG_COUNT),
    .BUFFER_DEPTH    (BUFFER_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_data_byte      (in_data_byte),
    .in_local_address  (in_local_address),
    .in_local_value    (in_local_value),
    .out_strobe        (out_strobe),
    .out_response_word (out_response_word),
    .out_byte_count    (out_byte_count),
    .out_final_res     (out_final_res),
    .out_status        (out_status)
  );

endmodule

/* rtl/mps_ctl.sv */
// Controller state machine of the Modbus PDU server.
`timescale 1ns / 1ps
module mps_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_mode,
  input  logic              in_last,
  input  mps_pkg::mps_sts_t sts,
  output mps_pkg::mps_cmd_t cmd,
  output logic              busy
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DEC   = 5'd2;
  localparam logic [4:0] S_TRUNC = 5'd3;
  localparam logic [4:0] S_EXC1  = 5'd4;
  localparam logic [4:0] S_EXC2  = 5'd5;
  localparam logic [4:0] S_RB_NB = 5'd6;
  localparam logic [4:0] S_RB_A  = 5'd7;
  localparam logic [4:0] S_RB_B  = 5'd8;
  localparam logic [4:0] S_RR_N  = 5'd9;
  localparam logic [4:0] S_RR_A  = 5'd10;
  localparam logic [4:0] S_RR_B  = 5'd11;
  localparam logic [4:0] S_RR_C  = 5'd12;
  localparam logic [4:0] S_W5    = 5'd13;
  localparam logic [4:0] S_W6    = 5'd14;
  localparam logic [4:0] S_EC_A  = 5'd15;
  localparam logic [4:0] S_EC_B  = 5'd16;
  localparam logic [4:0] S_W15_A = 5'd17;
  localparam logic [4:0] S_W15_B = 5'd18;
  localparam logic [4:0] S_W16_A = 5'd19;
  localparam logic [4:0] S_W16_B = 5'd20;
  localparam logic [4:0] S_W16_C = 5'd21;
  localparam logic [4:0] S_HDR   = 5'd22;
  localparam logic [4:0] S_DONE  = 5'd23;

  logic [4:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    cmd.accept = start && (state_r == S_IDLE);
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.accept && in_mode == mps_pkg::MODE_REQ && in_last) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.idx_clr = 1'b1;
        if (sts.trunc) state_nxt = S_TRUNC;
        else if (sts.exc) state_nxt = S_EXC1;
        else begin
          unique case (sts.cls)
            mps_pkg::CLS_RBIT: state_nxt = S_RB_NB;
            mps_pkg::CLS_RREG: state_nxt = S_RR_N;
            mps_pkg::CLS_W5:   state_nxt = S_W5;
            mps_pkg::CLS_W6:   state_nxt = S_W6;
            mps_pkg::CLS_W15:  state_nxt = S_W15_A;
            mps_pkg::CLS_W16:  state_nxt = S_W16_A;
            default:           state_nxt = S_EXC1;
          endcase
        end
      end
      S_TRUNC: begin
        cmd.emit_trunc = 1'b1;
        state_nxt = S_DONE;
      end
      S_EXC1: begin
        cmd.push = 1'b1;
        cmd.bsel = mps_pkg::BS_EXC_FC;
        state_nxt = S_EXC2;
      end
      S_EXC2: begin
        cmd.push = 1'b1;
        cmd.push_last = 1'b1;
        cmd.bsel = mps_pkg::BS_EXC_CODE;
        state_nxt = S_DONE;
      end
      S_RB_NB: begin
        cmd.push = 1'b1;
        cmd.bsel = mps_pkg::BS_NB;
        state_nxt = S_RB_A;
      end
      S_RB_A: state_nxt = S_RB_B;
      S_RB_B: begin
        cmd.acc_load = 1'b1;
        cmd.idx_inc = 1'b1;
        cmd.push = sts.byte_end || sts.last_elem;
        cmd.push_last = sts.last_elem;
        cmd.bsel = mps_pkg::BS_BITS;
        state_nxt = sts.last_elem ? S_DONE : S_RB_A;
      end
      S_RR_N: begin
        cmd.push = 1'b1;
        cmd.bsel = mps_pkg::BS_QTY2;
        state_nxt = S_RR_A;
      end
      S_RR_A: state_nxt = S_RR_B;
      S_RR_B: begin
        cmd.push = 1'b1;
        cmd.bsel = mps_pkg::BS_REG_HI;
        state_nxt = S_RR_C;
      end
      S_RR_C: begin
        cmd.push = 1'b1;
        cmd.push_last = sts.last_elem;
        cmd.bsel = mps_pkg::BS_REG_LO;
        cmd.idx_inc = 1'b1;
        state_nxt = sts.last_elem ? S_DONE : S_RR_A;
      end
      S_W5: begin
        cmd.wr_coil_one = 1'b1;
        state_nxt = S_EC_A;
      end
      S_W6: begin
        cmd.wr_hold_one = 1'b1;
        state_nxt = S_EC_A;
      end
      S_EC_A: begin
        cmd.asel = mps_pkg::AS_ECHO;
        state_nxt = S_EC_B;
      end
      S_EC_B: begin
        cmd.asel = mps_pkg::AS_ECHO;
        cmd.push = 1'b1;
        cmd.push_last = sts.echo_last;
        cmd.bsel = mps_pkg::BS_BUF;
        cmd.idx_inc = 1'b1;
        state_nxt = sts.echo_last ? S_DONE : S_EC_A;
      end
      S_W15_A: begin
        cmd.asel = mps_pkg::AS_COIL;
        state_nxt = S_W15_B;
      end
      S_W15_B: begin
        cmd.asel = mps_pkg::AS_COIL;
        cmd.wr_coil_bit = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.last_elem) begin
          cmd.idx_clr = 1'b1;
          state_nxt = S_HDR;
        end else if (sts.byte_end) state_nxt = S_W15_A;
        else state_nxt = S_W15_B;
      end
      S_W16_A: begin
        cmd.asel = mps_pkg::AS_HI;
        state_nxt = S_W16_B;
      end
      S_W16_B: begin
        cmd.asel = mps_pkg::AS_LO;
        cmd.hi_load = 1'b1;
        state_nxt = S_W16_C;
      end
      S_W16_C: begin
        cmd.wr_hold_reg = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.last_elem) begin
          cmd.idx_clr = 1'b1;
          state_nxt = S_HDR;
        end else state_nxt = S_W16_A;
      end
      S_HDR: begin
        cmd.push = 1'b1;
        cmd.push_last = sts.hdr_last;
        cmd.bsel = mps_pkg::BS_HDR;
        cmd.idx_inc = 1'b1;
        if (sts.hdr_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.len_clr = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

endmodule

/* rtl/mps_dp.sv */
// Datapath of the Modbus PDU server: areas, request buffer, checks, word packer.
`timescale 1ns / 1ps
module mps_dp #(
  parameter int COIL_COUNT      = 2048,
  parameter int DISCRETE_COUNT  = 2048,
  parameter int HOLDING_COUNT   = 256,
  parameter int INPUT_REG_COUNT = 256,
  parameter int BUFFER_DEPTH    = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mps_pkg::mps_cmd_t cmd,
  output mps_pkg::mps_sts_t sts,
  input  logic [1:0]        in_mode,
  input  logic [7:0]        in_data_byte,
  input  logic [15:0]       in_local_address,
  input  logic [15:0]       in_local_value,
  output logic              out_strobe,
  output logic [31:0]       out_response_word,
  output logic [2:0]        out_byte_count,
  output logic              out_final_res,
  output logic              out_status
);

  localparam int CAW = (COIL_COUNT > 1) ? $clog2(COIL_COUNT) : 1;
  localparam int DAW = (DISCRETE_COUNT > 1) ? $clog2(DISCRETE_COUNT) : 1;
  localparam int HAW = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
  localparam int IAW = (INPUT_REG_COUNT > 1) ? $clog2(INPUT_REG_COUNT) : 1;
  localparam int BAW = $clog2(BUFFER_DEPTH);
  localparam int LW  = $clog2(BUFFER_DEPTH + 2);
  localparam int MAX_A = (COIL_COUNT > DISCRETE_COUNT) ? COIL_COUNT : DISCRETE_COUNT;
  localparam int MAX_B = (HOLDING_COUNT > INPUT_REG_COUNT) ? HOLDING_COUNT : INPUT_REG_COUNT;
  localparam int MAX_C = (MAX_A > MAX_B) ? MAX_A : MAX_B;

  localparam logic [16:0] COIL_SZ = 17'(COIL_COUNT);
  localparam logic [16:0] DISC_SZ = 17'(DISCRETE_COUNT);
  localparam logic [16:0] HOLD_SZ = 17'(HOLDING_COUNT);
  localparam logic [16:0] IREG_SZ = 17'(INPUT_REG_COUNT);
  localparam logic [16:0] CLR_END = 17'(MAX_C);
  localparam logic [16:0] DEPTH17 = 17'(BUFFER_DEPTH);
  localparam logic [16:0] ECHO_MAX = 17'd256;
  localparam logic [LW-1:0] LEN_DEPTH = LW'(BUFFER_DEPTH);

  logic            coil_mem [COIL_COUNT];
  logic            disc_mem [DISCRETE_COUNT];
  logic [15:0]     hold_mem [HOLDING_COUNT];
  logic [15:0]     ireg_mem [INPUT_REG_COUNT];
  logic [7:0]      buf_mem  [BUFFER_DEPTH];

  logic            coil_rd_r, disc_rd_r;
  logic [15:0]     hold_rd_r, ireg_rd_r;
  logic [7:0]      buf_rd_r;

  logic [LW-1:0]   len_r;
  logic [7:0]      fc_r, bc_r, acc_r, hi_r;
  logic [15:0]     addr_r, qty_r, idx_r;
  logic [16:0]     clr_r;
  logic [31:0]     pk_word_r;
  logic [1:0]      pk_cnt_r;
  logic            out_vld_r, out_final_r, out_status_r;
  logic [31:0]     out_word_r;
  logic [2:0]      out_cnt_r;

  logic            acc_req, acc_disc, acc_ireg;
  logic [16:0]     elem_sum, sum_q, nb17, len17, bc6, kept, echo_n, buf_ra17;
  logic [1:0]      code;
  logic [2:0]      cls;
  logic            rbit;
  logic [15:0]     rreg;
  logic [7:0]      bits_byte, push_byte, hdr_byte;

  logic            coil_we, disc_we, hold_we, ireg_we;
  logic [CAW-1:0]  coil_wa;
  logic [DAW-1:0]  disc_wa;
  logic [HAW-1:0]  hold_wa;
  logic [IAW-1:0]  ireg_wa;
  logic            coil_wd, disc_wd;
  logic [15:0]     hold_wd, ireg_wd;

  assign acc_req  = cmd.accept && in_mode == mps_pkg::MODE_REQ;
  assign acc_disc = cmd.accept && in_mode == mps_pkg::MODE_DISC;
  assign acc_ireg = cmd.accept && in_mode == mps_pkg::MODE_IREG;

  assign elem_sum = {1'b0, addr_r} + {1'b0, idx_r};
  assign sum_q    = {1'b0, addr_r} + {1'b0, qty_r};
  assign nb17     = ({1'b0, qty_r} + 17'd7) >> 3;
  assign len17    = 17'(len_r);
  assign bc6      = {9'd0, bc_r} + 17'd6;
  assign kept     = (len17 > DEPTH17) ? DEPTH17 : len17;
  assign echo_n   = (kept > ECHO_MAX) ? ECHO_MAX : kept;

  always_comb begin
    unique case (cmd.asel)
      mps_pkg::AS_ECHO: buf_ra17 = {1'b0, idx_r};
      mps_pkg::AS_COIL: buf_ra17 = {4'd0, idx_r[15:3]} + 17'd6;
      mps_pkg::AS_HI:   buf_ra17 = {idx_r, 1'b0} + 17'd6;
      default:          buf_ra17 = {idx_r, 1'b0} + 17'd7;
    endcase
  end

  always_comb begin
    if (fc_r == mps_pkg::FC_RD_COILS || fc_r == mps_pkg::FC_RD_DISC) cls = mps_pkg::CLS_RBIT;
    else if (fc_r == mps_pkg::FC_RD_HOLD || fc_r == mps_pkg::FC_RD_IREG) cls = mps_pkg::CLS_RREG;
    else if (fc_r == mps_pkg::FC_WR_COIL) cls = mps_pkg::CLS_W5;
    else if (fc_r == mps_pkg::FC_WR_REG) cls = mps_pkg::CLS_W6;
    else if (fc_r == mps_pkg::FC_WR_COILS) cls = mps_pkg::CLS_W15;
    else if (fc_r == mps_pkg::FC_WR_REGS) cls = mps_pkg::CLS_W16;
    else cls = mps_pkg::CLS_OTHER;
  end

  always_comb begin
    code = mps_pkg::EXC_NONE;
    unique case (cls)
      mps_pkg::CLS_RBIT: begin
        if (qty_r == 16'd0 || {1'b0, qty_r} > mps_pkg::MAX_RBIT) code = mps_pkg::EXC_QTY;
        else if (sum_q > (fc_r[0] ? COIL_SZ : DISC_SZ)) code = mps_pkg::EXC_ADDR;
      end
      mps_pkg::CLS_RREG: begin
        if (qty_r == 16'd0 || {1'b0, qty_r} > mps_pkg::MAX_RREG) code = mps_pkg::EXC_QTY;
        else if (sum_q > (fc_r[0] ? HOLD_SZ : IREG_SZ)) code = mps_pkg::EXC_ADDR;
      end
      mps_pkg::CLS_W5: begin
        if (qty_r != 16'd0 && qty_r != mps_pkg::COIL_ON) code = mps_pkg::EXC_QTY;
        else if ({1'b0, addr_r} >= COIL_SZ) code = mps_pkg::EXC_ADDR;
      end
      mps_pkg::CLS_W6: begin
        if ({1'b0, addr_r} >= HOLD_SZ) code = mps_pkg::EXC_ADDR;
      end
      mps_pkg::CLS_W15: begin
        if (qty_r == 16'd0 || {1'b0, qty_r} > mps_pkg::MAX_W15 ||
            {9'd0, bc_r} != nb17 || len17 != bc6) code = mps_pkg::EXC_QTY;
        else if (sum_q > COIL_SZ) code = mps_pkg::EXC_ADDR;
      end
      mps_pkg::CLS_W16: begin
        if (qty_r == 16'd0 || {1'b0, qty_r} > mps_pkg::MAX_W16 ||
            {9'd0, bc_r} != {qty_r, 1'b0} || len17 != bc6) code = mps_pkg::EXC_QTY;
        else if (sum_q > HOLD_SZ) code = mps_pkg::EXC_ADDR;
      end
      default: code = mps_pkg::EXC_FUNC;
    endcase
  end

  always_comb begin
    sts.clr_done  = (clr_r == CLR_END);
    sts.trunc     = ((cls == mps_pkg::CLS_RBIT || cls == mps_pkg::CLS_RREG ||
                      cls == mps_pkg::CLS_W5 || cls == mps_pkg::CLS_W6) && len17 < 17'd5) ||
                    ((cls == mps_pkg::CLS_W15 || cls == mps_pkg::CLS_W16) && len17 < 17'd6);
    sts.exc       = (code != mps_pkg::EXC_NONE);
    sts.cls       = cls;
    sts.last_elem = (idx_r == qty_r - 16'd1);
    sts.byte_end  = (idx_r[2:0] == 3'd7);
    sts.echo_last = ({1'b0, idx_r} == echo_n - 17'd1);
    sts.hdr_last  = (idx_r == 16'd4);
  end

  assign rbit      = fc_r[0] ? coil_rd_r : disc_rd_r;
  assign rreg      = fc_r[0] ? hold_rd_r : ireg_rd_r;
  assign bits_byte = acc_r | (8'(rbit) << idx_r[2:0]);

  always_comb begin
    unique case (idx_r[2:0])
      3'd0:    hdr_byte = fc_r;
      3'd1:    hdr_byte = addr_r[15:8];
      3'd2:    hdr_byte = addr_r[7:0];
      3'd3:    hdr_byte = qty_r[15:8];
      3'd4:    hdr_byte = qty_r[7:0];
      default: hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    unique case (cmd.bsel)
      mps_pkg::BS_EXC_FC:   push_byte = fc_r | mps_pkg::EXC_FLAG;
      mps_pkg::BS_EXC_CODE: push_byte = {6'd0, code};
      mps_pkg::BS_NB:       push_byte = nb17[7:0];
      mps_pkg::BS_BITS:     push_byte = bits_byte;
      mps_pkg::BS_QTY2:     push_byte = {qty_r[6:0], 1'b0};
      mps_pkg::BS_REG_HI:   push_byte = rreg[15:8];
      mps_pkg::BS_REG_LO:   push_byte = rreg[7:0];
      mps_pkg::BS_BUF:      push_byte = buf_rd_r;
      mps_pkg::BS_HDR:      push_byte = hdr_byte;
      default:              push_byte = 8'd0;
    endcase
  end

  always_comb begin
    coil_we = 1'b0;
    coil_wa = CAW'(clr_r);
    coil_wd = 1'b0;
    priority if (cmd.clr_step) begin
      coil_we = clr_r < COIL_SZ;
    end else if (cmd.wr_coil_one) begin
      coil_we = 1'b1;
      coil_wa = CAW'(addr_r);
      coil_wd = (qty_r == mps_pkg::COIL_ON);
    end else if (cmd.wr_coil_bit) begin
      coil_we = 1'b1;
      coil_wa = CAW'(elem_sum);
      coil_wd = buf_rd_r[idx_r[2:0]];
    end
  end

  always_comb begin
    disc_we = 1'b0;
    disc_wa = DAW'(clr_r);
    disc_wd = 1'b0;
    priority if (cmd.clr_step) begin
      disc_we = clr_r < DISC_SZ;
    end else if (acc_disc) begin
      disc_we = {1'b0, in_local_address} < DISC_SZ;
      disc_wa = DAW'(in_local_address);
      disc_wd = in_local_value[0];
    end
  end

  always_comb begin
    hold_we = 1'b0;
    hold_wa = HAW'(clr_r);
    hold_wd = 16'd0;
    priority if (cmd.clr_step) begin
      hold_we = clr_r < HOLD_SZ;
    end else if (cmd.wr_hold_one) begin
      hold_we = 1'b1;
      hold_wa = HAW'(addr_r);
      hold_wd = qty_r;
    end else if (cmd.wr_hold_reg) begin
      hold_we = 1'b1;
      hold_wa = HAW'(elem_sum);
      hold_wd = {hi_r, buf_rd_r};
    end
  end

  always_comb begin
    ireg_we = 1'b0;
    ireg_wa = IAW'(clr_r);
    ireg_wd = 16'd0;
    priority if (cmd.clr_step) begin
      ireg_we = clr_r < IREG_SZ;
    end else if (acc_ireg) begin
      ireg_we = {1'b0, in_local_address} < IREG_SZ;
      ireg_wa = IAW'(in_local_address);
      ireg_wd = in_local_value;
    end
  end

  always_ff @(posedge clk) begin
    if (coil_we) coil_mem[coil_wa] <= coil_wd;
    coil_rd_r <= coil_mem[CAW'(elem_sum)];
  end

  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[disc_wa] <= disc_wd;
    disc_rd_r <= disc_mem[DAW'(elem_sum)];
  end

  always_ff @(posedge clk) begin
    if (hold_we) hold_mem[hold_wa] <= hold_wd;
    hold_rd_r <= hold_mem[HAW'(elem_sum)];
  end

  always_ff @(posedge clk) begin
    if (ireg_we) ireg_mem[ireg_wa] <= ireg_wd;
    ireg_rd_r <= ireg_mem[IAW'(elem_sum)];
  end

  always_ff @(posedge clk) begin
    if (acc_req && len_r < LEN_DEPTH) buf_mem[BAW'(len_r)] <= in_data_byte;
    buf_rd_r <= buf_mem[BAW'(buf_ra17)];
  end

  // capture the header fields as the request bytes arrive
  always_ff @(posedge clk) begin
    if (acc_req) begin
      if (len_r == LW'(0)) fc_r <= in_data_byte;
      if (len_r == LW'(1)) addr_r[15:8] <= in_data_byte;
      if (len_r == LW'(2)) addr_r[7:0] <= in_data_byte;
      if (len_r == LW'(3)) qty_r[15:8] <= in_data_byte;
      if (len_r == LW'(4)) qty_r[7:0] <= in_data_byte;
      if (len_r == LW'(5)) bc_r <= in_data_byte;
    end
    if (cmd.hi_load) hi_r <= buf_rd_r;
    if (cmd.idx_clr) acc_r <= 8'd0;
    else if (cmd.acc_load) acc_r <= cmd.push ? 8'd0 : bits_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      idx_r <= 16'd0;
      clr_r <= 17'd0;
    end else begin
      if (cmd.len_clr) len_r <= '0;
      else if (acc_req && len_r <= LEN_DEPTH) len_r <= len_r + LW'(1);
      if (cmd.idx_clr) idx_r <= 16'd0;
      else if (cmd.idx_inc) idx_r <= idx_r + 16'd1;
      if (cmd.clr_step && clr_r != CLR_END) clr_r <= clr_r + 17'd1;
    end
  end

  // pack response bytes into big-endian beats
  logic [31:0] merged;
  always_comb begin
    unique case (pk_cnt_r)
      2'd0:    merged = pk_word_r | {push_byte, 24'd0};
      2'd1:    merged = pk_word_r | {8'd0, push_byte, 16'd0};
      2'd2:    merged = pk_word_r | {16'd0, push_byte, 8'd0};
      default: merged = pk_word_r | {24'd0, push_byte};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_word_r <= 32'd0;
      pk_cnt_r  <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= 1'b0;
      if (cmd.emit_trunc) begin
        out_vld_r    <= 1'b1;
        out_word_r   <= 32'd0;
        out_cnt_r    <= 3'd0;
        out_final_r  <= 1'b1;
        out_status_r <= 1'b1;
      end else if (cmd.push) begin
        if (pk_cnt_r == 2'd3 || cmd.push_last) begin
          out_vld_r    <= 1'b1;
          out_word_r   <= merged;
          out_cnt_r    <= {1'b0, pk_cnt_r} + 3'd1;
          out_final_r  <= cmd.push_last;
          out_status_r <= 1'b0;
          pk_word_r    <= 32'd0;
          pk_cnt_r     <= 2'd0;
        end else begin
          pk_word_r <= merged;
          pk_cnt_r  <= pk_cnt_r + 2'd1;
        end
      end
    end
  end

  assign out_strobe        = out_vld_r;
  assign out_response_word = out_word_r;
  assign out_byte_count    = out_cnt_r;
  assign out_final_res     = out_final_r;
  assign out_status        = out_status_r;

endmodule
